// File: rtl/protobuf_wire_token_decoder_assert.svh
// Assertion macros used by the top-level decoder file.
`ifndef PROTOBUF_WIRE_TOKEN_DECODER_ASSERT_SVH
`define PROTOBUF_WIRE_TOKEN_DECODER_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define PWTD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("protobuf_wire_token_decoder assertion failed");

// Checks that a condition is never true outside reset.
`define PWTD_ASSERT_NEVER(label, cond) \
  `PWTD_ASSERT(label, !(cond))

`endif

// File: rtl/pwtd_pkg.sv
package pwtd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_VARINT,
    PH_PAYLOAD,
    PH_FIXED
  } phase_e;

  localparam logic [2:0] CMD_UINT    = 3'd0;
  localparam logic [2:0] CMD_SINT32  = 3'd1;
  localparam logic [2:0] CMD_SINT64  = 3'd2;
  localparam logic [2:0] CMD_KEY     = 3'd3;
  localparam logic [2:0] CMD_LEN     = 3'd4;
  localparam logic [2:0] CMD_FIXED32 = 3'd5;
  localparam logic [2:0] CMD_FIXED64 = 3'd6;
  localparam logic [2:0] CMD_NONE    = 3'd7;

  localparam logic [2:0] OUT_UINT    = 3'd0;
  localparam logic [2:0] OUT_SINT32  = 3'd1;
  localparam logic [2:0] OUT_SINT64  = 3'd2;
  localparam logic [2:0] OUT_KEY     = 3'd3;
  localparam logic [2:0] OUT_LEN     = 3'd4;
  localparam logic [2:0] OUT_PAYLOAD = 3'd5;
  localparam logic [2:0] OUT_FIXED32 = 3'd6;
  localparam logic [2:0] OUT_FIXED64 = 3'd7;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam logic [3:0] VARINT_MAX_GROUPS = 4'd10;
  localparam logic [2:0] FIXED32_LAST = 3'd3;
  localparam logic [2:0] FIXED64_LAST = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  data_byte;
    logic        at_end;
    logic [16:0] avail_after;
    logic        short32;
    logic        short64;
  } item_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [63:0] value;
    logic [2:0]  wire_type;
    logic [31:0] field_number;
    logic [7:0]  payload_byte;
    logic        last_of_payload;
    logic        error;
  } res_t;

  function automatic logic [2:0] kind_out(input logic [2:0] cmd);
    logic [2:0] k;
    case (cmd)
      CMD_FIXED32: k = OUT_FIXED32;
      CMD_FIXED64: k = OUT_FIXED64;
      default:     k = cmd;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/pwtd_fifo.sv
module pwtd_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = $clog2(pwtd_pkg::FIFO_DEPTH);
  localparam int CntW = $clog2(pwtd_pkg::FIFO_DEPTH + 1);

  logic [Width-1:0] mem_q [pwtd_pkg::FIFO_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(pwtd_pkg::FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/pwtd_front.sv
module pwtd_front #(
  parameter longint unsigned MaxBufferBytes = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  logic [2:0]      cmd_i,
  input  logic [7:0]      data_byte_i,
  input  logic [16:0]     bytes_left_i,
  output logic            item_valid_o,
  output pwtd_pkg::item_t item_o,
  input  logic            item_pop_i
);

  pwtd_pkg::item_t item_in;
  logic [16:0]     left_clamped;
  logic            item_empty;

  always_comb begin
    if (64'(bytes_left_i) > MaxBufferBytes) begin
      left_clamped = 17'(MaxBufferBytes);
    end else begin
      left_clamped = bytes_left_i;
    end
    item_in.cmd         = cmd_i;
    item_in.data_byte   = data_byte_i;
    item_in.at_end      = (left_clamped <= 17'd1);
    item_in.avail_after = (left_clamped == '0) ? '0 : left_clamped - 17'd1;
    item_in.short32     = (left_clamped < 17'd4);
    item_in.short64     = (left_clamped < 17'd8);
  end

  pwtd_fifo #(
    .Width($bits(pwtd_pkg::item_t))
  ) u_item_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (item_in),
    .full_o (full_o),
    .pop_i  (item_pop_i),
    .data_o (item_o),
    .empty_o(item_empty)
  );

  assign item_valid_o = !item_empty;

endmodule

// File: rtl/pwtd_back.sv
module pwtd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  pwtd_pkg::item_t item_i,
  output logic            item_pop_o,
  input  logic            res_full_i,
  output logic            res_push_o,
  output pwtd_pkg::res_t  res_o
);

  pwtd_pkg::phase_e phase_q, phase_d, varint_phase, fixed_phase;
  logic [2:0]       kind_q, kind_d, kind_cur;
  logic [63:0]      acc_q, acc_d, base_acc, acc_var, acc_fix;
  logic [3:0]       grp_q, grp_d, base_grp, grp_var;
  logic [2:0]       fix_q, fix_d, base_fix;
  logic [16:0]      rem_q, rem_d;
  logic [6:0]       vshift;
  logic             take, idle, grp_room, cont, len_bad, fix_last, fixed_short;
  logic             varint_hit, fixed_hit, res_hit;
  pwtd_pkg::res_t   varint_res, fixed_res, res;
  logic [31:0]      zz32;

  assign take       = item_valid_i && !res_full_i;
  assign item_pop_o = take;
  assign idle       = (phase_q == pwtd_pkg::PH_IDLE);
  assign kind_cur   = idle ? item_i.cmd : kind_q;
  assign base_acc   = idle ? '0 : acc_q;
  assign base_grp   = idle ? '0 : grp_q;
  assign base_fix   = idle ? '0 : fix_q;
  assign cont       = item_i.data_byte[7];

  // Each varint group lands seven bits further up; bits past the top are lost.
  assign grp_room = (base_grp < pwtd_pkg::VARINT_MAX_GROUPS);
  assign vshift   = {base_grp, 3'b000} - {3'b000, base_grp};
  assign acc_var  = base_acc | (grp_room ? ({57'b0, item_i.data_byte[6:0]} << vshift) : '0);
  assign grp_var  = grp_room ? base_grp + 4'd1 : base_grp;
  assign len_bad  = (acc_var > {47'b0, item_i.avail_after});

  assign acc_fix  = base_acc | ({56'b0, item_i.data_byte} << {base_fix, 3'b000});
  assign fix_last = (kind_cur == pwtd_pkg::CMD_FIXED64) ? (base_fix == pwtd_pkg::FIXED64_LAST)
                                                        : (base_fix == pwtd_pkg::FIXED32_LAST);
  assign fixed_short = (item_i.cmd == pwtd_pkg::CMD_FIXED64) ? item_i.short64
                                                             : item_i.short32;
  assign zz32 = (acc_var[31:0] >> 1) ^ {32{acc_var[0]}};

  always_comb begin
    if (cont) begin
      varint_phase = item_i.at_end ? pwtd_pkg::PH_IDLE : pwtd_pkg::PH_VARINT;
    end else if (kind_cur == pwtd_pkg::CMD_LEN && !len_bad && acc_var != '0) begin
      varint_phase = pwtd_pkg::PH_PAYLOAD;
    end else begin
      varint_phase = pwtd_pkg::PH_IDLE;
    end
    fixed_phase = fix_last ? pwtd_pkg::PH_IDLE : pwtd_pkg::PH_FIXED;
  end

  always_comb begin
    phase_d = phase_q;
    if (take) begin
      case (phase_q)
        pwtd_pkg::PH_IDLE: begin
          if (item_i.cmd == pwtd_pkg::CMD_NONE) begin
            phase_d = pwtd_pkg::PH_IDLE;
          end else if (item_i.cmd <= pwtd_pkg::CMD_LEN) begin
            phase_d = varint_phase;
          end else if (fixed_short) begin
            phase_d = pwtd_pkg::PH_IDLE;
          end else begin
            phase_d = fixed_phase;
          end
        end
        pwtd_pkg::PH_VARINT: begin
          phase_d = varint_phase;
        end
        pwtd_pkg::PH_PAYLOAD: begin
          phase_d = (rem_q <= 17'd1) ? pwtd_pkg::PH_IDLE : pwtd_pkg::PH_PAYLOAD;
        end
        pwtd_pkg::PH_FIXED: begin
          phase_d = fixed_phase;
        end
        default: begin
          phase_d = pwtd_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    kind_d = kind_q;
    acc_d  = acc_q;
    grp_d  = grp_q;
    fix_d  = fix_q;
    rem_d  = rem_q;
    if (take) begin
      kind_d = kind_cur;
      if (phase_q == pwtd_pkg::PH_PAYLOAD) begin
        rem_d = (rem_q <= 17'd1) ? '0 : rem_q - 17'd1;
      end else if (kind_cur <= pwtd_pkg::CMD_LEN) begin
        acc_d = acc_var;
        grp_d = grp_var;
        fix_d = '0;
        if (varint_phase == pwtd_pkg::PH_PAYLOAD) begin
          rem_d = acc_var[16:0];
        end
      end else begin
        acc_d = acc_fix;
        grp_d = '0;
        fix_d = fix_last ? '0 : base_fix + 3'd1;
      end
    end
  end

  always_comb begin
    varint_res = '0;
    varint_hit = 1'b1;
    varint_res.out_kind = kind_cur;
    if (cont) begin
      varint_hit       = item_i.at_end;
      varint_res.error = 1'b1;
    end else begin
      case (kind_cur)
        pwtd_pkg::CMD_SINT32: begin
          varint_res.value = {{32{zz32[31]}}, zz32};
        end
        pwtd_pkg::CMD_SINT64: begin
          varint_res.value = (acc_var >> 1) ^ {64{acc_var[0]}};
        end
        pwtd_pkg::CMD_KEY: begin
          varint_res.value        = acc_var;
          varint_res.wire_type    = acc_var[2:0];
          varint_res.field_number = acc_var[34:3];
        end
        pwtd_pkg::CMD_LEN: begin
          varint_res.error = len_bad;
          varint_res.value = len_bad ? '0 : acc_var;
        end
        default: begin
          varint_res.out_kind = pwtd_pkg::OUT_UINT;
          varint_res.value    = acc_var;
        end
      endcase
    end
  end

  always_comb begin
    fixed_res          = '0;
    fixed_res.out_kind = pwtd_pkg::kind_out(kind_cur);
    fixed_res.value    = acc_fix;
    fixed_hit          = fix_last;
  end

  always_comb begin
    res     = '0;
    res_hit = 1'b0;
    case (phase_q)
      pwtd_pkg::PH_IDLE: begin
        if (item_i.cmd == pwtd_pkg::CMD_NONE) begin
          res_hit = 1'b0;
        end else if (item_i.cmd <= pwtd_pkg::CMD_LEN) begin
          res     = varint_res;
          res_hit = varint_hit;
        end else if (fixed_short) begin
          res.out_kind = pwtd_pkg::kind_out(item_i.cmd);
          res.error    = 1'b1;
          res_hit      = 1'b1;
        end else begin
          res     = fixed_res;
          res_hit = fixed_hit;
        end
      end
      pwtd_pkg::PH_VARINT: begin
        res     = varint_res;
        res_hit = varint_hit;
      end
      pwtd_pkg::PH_PAYLOAD: begin
        res.out_kind        = pwtd_pkg::OUT_PAYLOAD;
        res.payload_byte    = item_i.data_byte;
        res.last_of_payload = (rem_q <= 17'd1);
        res_hit             = 1'b1;
      end
      pwtd_pkg::PH_FIXED: begin
        res     = fixed_res;
        res_hit = fixed_hit;
      end
      default: begin
        res_hit = 1'b0;
      end
    endcase
  end

  assign res_push_o = take && res_hit;
  assign res_o      = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pwtd_pkg::PH_IDLE;
      kind_q  <= '0;
      acc_q   <= '0;
      grp_q   <= '0;
      fix_q   <= '0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      acc_q   <= acc_d;
      grp_q   <= grp_d;
      fix_q   <= fix_d;
      rem_q   <= rem_d;
    end
  end

endmodule

// File: rtl/protobuf_wire_token_decoder.sv
// Throughput: one byte per cycle while results are popped, set by the combinational
// shift-or of the accumulator in the decode stage.
// Two-entry queues sit in front of and behind the decode stage.
// Reset (asynchronous, active low) empties both queues and leaves the decoder idle.
`include "protobuf_wire_token_decoder_assert.svh"

module protobuf_wire_token_decoder #(
  parameter longint unsigned MAX_BUFFER_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic [16:0] bytes_left_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_kind_o,
  output logic [63:0] value_o,
  output logic [2:0]  wire_type_o,
  output logic [31:0] field_number_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_of_payload_o,
  output logic        error_o
);

  pwtd_pkg::item_t item;
  pwtd_pkg::res_t  res_in, res_out;
  logic            item_valid, item_pop, res_full, res_push;

  pwtd_front #(
    .MaxBufferBytes(MAX_BUFFER_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .cmd_i       (cmd_i),
    .data_byte_i (data_byte_i),
    .bytes_left_i(bytes_left_i),
    .item_valid_o(item_valid),
    .item_o      (item),
    .item_pop_i  (item_pop)
  );

  pwtd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_pop_o  (item_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  pwtd_fifo #(
    .Width($bits(pwtd_pkg::res_t))
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign out_kind_o        = res_out.out_kind;
  assign value_o           = res_out.value;
  assign wire_type_o       = res_out.wire_type;
  assign field_number_o    = res_out.field_number;
  assign payload_byte_o    = res_out.payload_byte;
  assign last_of_payload_o = res_out.last_of_payload;
  assign error_o           = res_out.error;

  `PWTD_ASSERT(a_error_value_zero, (!empty && error_o) |-> (value_o == '0))
  `PWTD_ASSERT(a_last_only_payload,
               (!empty && last_of_payload_o) |-> (out_kind_o == pwtd_pkg::OUT_PAYLOAD))
  `PWTD_ASSERT(a_key_fields_only_key,
               (!empty && out_kind_o != pwtd_pkg::OUT_KEY) |->
               (wire_type_o == '0 && field_number_o == '0))
  `PWTD_ASSERT_NEVER(a_push_into_full_result, res_push && res_full)

endmodule
